// ===== rtl/mips_itype_execute_core_assert.svh =====
// ----------------------------------------------------------------------------
// mips_itype_execute_core_assert.svh
// Assertion macros for the I-type execute core.
// ----------------------------------------------------------------------------
`ifndef MIPS_ITYPE_EXECUTE_CORE_ASSERT_SVH
`define MIPS_ITYPE_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication, checked on clk_i, off during reset
`define MIE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mips_itype_execute_core: assertion failed");

// next-cycle implication, checked on clk_i, off during reset
`define MIE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mips_itype_execute_core: assertion failed");

`endif

// ===== rtl/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// Types and constants of the I-type execute core.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned REG_AW = 5;
  localparam int unsigned IMM_W  = 16;
  localparam int unsigned CMD_W  = 4;

  localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;
  localparam logic [DATA_W-1:0] BYTE_MASK = 32'h0000_00FF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADDI = 4'd0,
    CMD_LW   = 4'd1,
    CMD_LH   = 4'd2,
    CMD_LHU  = 4'd3,
    CMD_LB   = 4'd4,
    CMD_LBU  = 4'd5,
    CMD_SW   = 4'd6,
    CMD_SH   = 4'd7,
    CMD_SB   = 4'd8,
    CMD_LUI  = 4'd9,
    CMD_ANDI = 4'd10,
    CMD_ORI  = 4'd11,
    CMD_NORI = 4'd12,
    CMD_SLTI = 4'd13,
    CMD_BEQ  = 4'd14,
    CMD_BNE  = 4'd15
  } cmd_e;

  // execute -> writeback stage
  typedef struct packed {
    cmd_e              cmd;
    logic [REG_AW-1:0] rt;
    logic              wr;
    logic              mw;
    logic              taken;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] npc;
    logic [1:0]        lane;
  } exe_t;

  function automatic logic [DATA_W-1:0] sext_imm(input logic [IMM_W-1:0] imm);
    return {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
  endfunction

endpackage

// ===== rtl/mips_itype_execute_core.sv =====
// ----------------------------------------------------------------------------
// mips_itype_execute_core
// Executes one MIPS-style I-type instruction per transaction against a
// 32x32 register file and a little-endian byte data memory.
//
// Takes one instruction per cycle while in_stall_o is low. Its result
// passes the execute, writeback and output registers, and waits while
// out_stall_i holds the output. The register file is read at acceptance,
// execute and the memory access take the execute stage, and the writeback
// stage writes the output register. The register file is a RAM with two
// read ports and one write port, with forwarding from writeback. Data
// memory is four byte-lane RAMs of MEM_BYTES/4 rows each, accessed in the
// execute stage, so loads and stores stay in program order. MEM_BYTES must
// be a power of two. After reset a clearing pass over max(MEM_BYTES/4, 32)
// addresses zeroes both memories; in_stall_o is high during it.
// ----------------------------------------------------------------------------
`include "mips_itype_execute_core_assert.svh"

module mips_itype_execute_core #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mie_pkg::CMD_W-1:0]         command_i,
  input  logic [mie_pkg::REG_AW-1:0]        source_reg_i,
  input  logic [mie_pkg::REG_AW-1:0]        target_reg_i,
  input  logic [mie_pkg::IMM_W-1:0]         immediate_i,
  input  logic [mie_pkg::DATA_W-1:0]        current_pc_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              reg_write_o,
  output logic [mie_pkg::DATA_W-1:0]        write_value_o,
  output logic                              mem_write_o,
  output logic                              branch_taken_o,
  output logic [mie_pkg::DATA_W-1:0]        next_pc_o
);
  import mie_pkg::*;

  localparam int unsigned ROWS     = MEM_BYTES / 4;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned NUM_REGS = 2 ** REG_AW;
  localparam int unsigned CLR_N    = (ROWS > NUM_REGS) ? ROWS : NUM_REGS;
  localparam int unsigned CLR_W    = $clog2(CLR_N);

  // storage
  logic [DATA_W-1:0] rf_ram [NUM_REGS];
  logic [7:0]        dm_ram [4][ROWS];

  // clearing pass
  logic             clr_busy_q;
  logic [CLR_W-1:0] clr_cnt_q;
  logic             rf_clr;

  // execute stage
  logic              b_valid_q;
  cmd_e              b_cmd_q;
  logic [REG_AW-1:0] b_rs_q;
  logic [REG_AW-1:0] b_rt_q;
  logic [IMM_W-1:0]  b_imm_q;
  logic [DATA_W-1:0] b_pc_q;
  logic              b_byp_a_q;
  logic              b_byp_b_q;
  logic [DATA_W-1:0] b_byp_a_val_q;
  logic [DATA_W-1:0] b_byp_b_val_q;
  logic [DATA_W-1:0] rf_rd_a_q;
  logic [DATA_W-1:0] rf_rd_b_q;

  // writeback stage
  logic              c_valid_q;
  exe_t              c_q;
  exe_t              exe_d;
  logic [7:0]        dm_rd_q [4];
  logic [DATA_W-1:0] c_val;
  logic [DATA_W-1:0] ld_word;

  // output register
  logic              out_valid_q;
  logic              reg_write_q;
  logic [DATA_W-1:0] write_value_q;
  logic              mem_write_q;
  logic              branch_taken_q;
  logic [DATA_W-1:0] next_pc_q;

  // handshake
  logic in_fire;
  logic adv_b;
  logic adv_c;
  logic rf_we;

  // execute datapath
  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] simm;
  logic [DATA_W-1:0] addr;
  logic [DATA_W-1:0] pc4;
  logic [1:0]        lane;
  logic [ROW_W-1:0]  row0;
  logic [ROW_W-1:0]  row1;
  logic              is_load;
  logic              is_store;
  logic [2:0]        st_cnt;
  logic              dm_re;
  logic [ROW_W-1:0]  bank_row [4];
  logic              bank_we  [4];
  logic [7:0]        bank_wd  [4];

  assign adv_c      = c_valid_q && (!out_valid_q || !out_stall_i);
  assign adv_b      = b_valid_q && (!c_valid_q || adv_c);
  assign in_stall_o = clr_busy_q || (b_valid_q && !adv_b);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign rf_we      = adv_c && c_q.wr;
  assign rf_clr     = clr_busy_q && ({1'b0, clr_cnt_q} < (CLR_W+1)'(NUM_REGS));

  // ---------------- execute ----------------
  always_comb begin
    if (c_valid_q && c_q.wr && (c_q.rt == b_rs_q)) begin
      opa = c_val;
    end else if (b_byp_a_q) begin
      opa = b_byp_a_val_q;
    end else begin
      opa = rf_rd_a_q;
    end
    if (c_valid_q && c_q.wr && (c_q.rt == b_rt_q)) begin
      opb = c_val;
    end else if (b_byp_b_q) begin
      opb = b_byp_b_val_q;
    end else begin
      opb = rf_rd_b_q;
    end
  end

  assign simm = sext_imm(b_imm_q);
  assign addr = opa + simm;
  assign pc4  = b_pc_q + DATA_W'(4);
  assign lane = addr[1:0];
  assign row0 = addr[ROW_W+1:2];
  assign row1 = row0 + ROW_W'(1);

  always_comb begin
    exe_d       = '0;
    exe_d.cmd   = b_cmd_q;
    exe_d.rt    = b_rt_q;
    exe_d.wr    = 1'b1;
    exe_d.npc   = pc4;
    exe_d.lane  = lane;
    is_load     = 1'b0;
    is_store    = 1'b0;
    st_cnt      = 3'd0;
    case (b_cmd_q)
      CMD_ADDI: exe_d.val = addr;
      CMD_LW, CMD_LH, CMD_LHU, CMD_LB, CMD_LBU: is_load = 1'b1;
      CMD_SW: begin
        exe_d.wr = 1'b0;
        exe_d.mw = 1'b1;
        is_store = 1'b1;
        st_cnt   = 3'd4;
      end
      CMD_SH: begin
        exe_d.wr = 1'b0;
        exe_d.mw = 1'b1;
        is_store = 1'b1;
        st_cnt   = 3'd2;
      end
      CMD_SB: begin
        exe_d.wr = 1'b0;
        exe_d.mw = 1'b1;
        is_store = 1'b1;
        st_cnt   = 3'd1;
      end
      CMD_LUI:  exe_d.val = {b_imm_q, {(DATA_W-IMM_W){1'b0}}};
      CMD_ANDI: exe_d.val = opa & {{(DATA_W-IMM_W){1'b0}}, b_imm_q};
      CMD_ORI:  exe_d.val = opa | {{(DATA_W-IMM_W){1'b0}}, b_imm_q};
      CMD_NORI: exe_d.val = ~(opa | {{(DATA_W-IMM_W){1'b0}}, b_imm_q});
      CMD_SLTI: exe_d.val = {{(DATA_W-1){1'b0}}, ($signed(opa) < $signed(simm))};
      CMD_BEQ, CMD_BNE: begin
        exe_d.wr    = 1'b0;
        exe_d.taken = (opa == opb) ^ (b_cmd_q == CMD_BNE);
        if (exe_d.taken) begin
          exe_d.npc = pc4 + {simm[DATA_W-3:0], 2'b00};
        end
      end
      default: exe_d.wr = 1'b0;
    endcase
  end

  // byte lanes: byte k of the access sits in lane (addr + k) mod 4
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [1:0] k;
      k           = 2'(j) - lane;
      bank_row[j] = (2'(j) < lane) ? row1 : row0;
      bank_we[j]  = adv_b && is_store && ({1'b0, k} < st_cnt);
      bank_wd[j]  = opb[8*k +: 8];
    end
  end

  assign dm_re = adv_b && is_load;

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 4; j++) begin
      if (clr_busy_q) begin
        dm_ram[j][clr_cnt_q[ROW_W-1:0]] <= '0;
      end else if (bank_we[j]) begin
        dm_ram[j][bank_row[j]] <= bank_wd[j];
      end
      if (dm_re) begin
        dm_rd_q[j] <= dm_ram[j][bank_row[j]];
      end
    end
  end

  // ---------------- register file ----------------
  always_ff @(posedge clk_i) begin
    if (rf_clr) begin
      rf_ram[clr_cnt_q[REG_AW-1:0]] <= '0;
    end else if (rf_we) begin
      rf_ram[c_q.rt] <= c_val;
    end
    if (in_fire) begin
      rf_rd_a_q <= rf_ram[source_reg_i];
      rf_rd_b_q <= rf_ram[target_reg_i];
    end
  end

  // ---------------- writeback ----------------
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_word[8*k +: 8] = dm_rd_q[2'(k) + c_q.lane];
    end
  end

  always_comb begin
    case (c_q.cmd)
      CMD_LW:  c_val = ld_word;
      CMD_LH:  c_val = {{(DATA_W-16){ld_word[15]}}, ld_word[15:0]};
      CMD_LHU: c_val = ld_word & HALF_MASK;
      CMD_LB:  c_val = {{(DATA_W-8){ld_word[7]}}, ld_word[7:0]};
      CMD_LBU: c_val = ld_word & BYTE_MASK;
      default: c_val = c_q.val;
    endcase
  end

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
        if (clr_cnt_q == CLR_W'(CLR_N - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_fire) begin
        b_valid_q <= 1'b1;
      end else if (adv_b) begin
        b_valid_q <= 1'b0;
      end
      if (adv_b) begin
        c_valid_q <= 1'b1;
      end else if (adv_c) begin
        c_valid_q <= 1'b0;
      end
      if (adv_c) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_cmd_q       <= cmd_e'(command_i);
      b_rs_q        <= source_reg_i;
      b_rt_q        <= target_reg_i;
      b_imm_q       <= immediate_i;
      b_pc_q        <= current_pc_i;
      // writeback landing in the same cycle as the read
      b_byp_a_q     <= rf_we && (c_q.rt == source_reg_i);
      b_byp_b_q     <= rf_we && (c_q.rt == target_reg_i);
      b_byp_a_val_q <= c_val;
      b_byp_b_val_q <= c_val;
    end
    if (adv_b) begin
      c_q <= exe_d;
    end
    if (adv_c) begin
      reg_write_q    <= c_q.wr;
      write_value_q  <= c_q.wr ? c_val : '0;
      mem_write_q    <= c_q.mw;
      branch_taken_q <= c_q.taken;
      next_pc_q      <= c_q.npc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign reg_write_o    = reg_write_q;
  assign write_value_o  = write_value_q;
  assign mem_write_o    = mem_write_q;
  assign branch_taken_o = branch_taken_q;
  assign next_pc_o      = next_pc_q;

  // ---------------- assertions ----------------
  `MIE_ASSERT_IMP(a_clr_empty, clr_busy_q, !b_valid_q && !c_valid_q && !out_valid_q)
  `MIE_ASSERT_IMP(a_out_excl, out_valid_q, $onehot0({reg_write_q, mem_write_q, branch_taken_q}))
  `MIE_ASSERT_NXT(a_wb_hold, c_valid_q && !adv_c, c_valid_q && $stable(c_q))

endmodule
